// ----- rtl/core/nearest_neighbor_image_scaler_top_assert.svh -----
// Assertion macros used by the checker file of the scaler.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NNIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scaler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NNIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scaler assertion failed");

`endif

// ----- rtl/core/nnis_pkg.sv -----
package nnis_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int STORE_DEPTH = 65536;
  localparam int FRAC_BITS   = 16;

  localparam int DIM_W      = 11;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int STEP_W     = DIM_W + FRAC_BITS;
  localparam int PROD_W     = COORD_W + STEP_W;
  localparam int SRC_ADDR_W = COORD_W + DIM_W;
  localparam int IDX_W      = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int PIX_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W,
    CFG_SRC_H,
    CFG_DST_W,
    CFG_DST_H,
    CFG_ALPHA
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_COL,
    S_DIV_ROW,
    S_MUL,
    S_ADDR,
    S_READ,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_we;
    logic emit_start;
    logic div_start;
    logic div_row;
    logic step_col_we;
    logic step_row_we;
    logic mul_en;
    logic addr_en;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic cfg_hit;
  } sts_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/nnis_div.sv -----
module nnis_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nnis_pkg::STEP_W-1:0] dividend_i,
  input  logic [nnis_pkg::DIM_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [nnis_pkg::STEP_W-1:0] quot_o
);
  import nnis_pkg::*;

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DIM_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] quo_q, quo_d;
  logic [DIM_W-1:0]  div_q, div_d;
  logic [DIM_W:0]    trial;
  logic              ge;

  always_comb begin
    trial = {rem_q, quo_q[STEP_W-1]};
    ge    = trial >= {1'b0, div_q};
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(STEP_W);
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      rem_d  = ge ? DIM_W'(trial - {1'b0, div_q}) : trial[DIM_W-1:0];
      quo_d  = {quo_q[STEP_W-2:0], ge};
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/core/nnis_ctrl.sv -----
module nnis_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  input  logic               out_ready_i,
  input  nnis_pkg::sts_t     sts_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output nnis_pkg::cmd_t     cmd_o
);
  import nnis_pkg::*;

  state_e state_q, state_d;
  logic   steps_ready_q, steps_ready_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.emit_start = 1'b1;
            if (steps_ready_q) begin
              state_d = S_MUL;
            end else begin
              cmd.div_start = 1'b1;
              state_d       = S_DIV_COL;
            end
          end
        end
      end
      S_DIV_COL: begin
        if (sts_i.div_done) begin
          cmd.step_col_we = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_row     = 1'b1;
          state_d         = S_DIV_ROW;
        end
      end
      S_DIV_ROW: begin
        if (sts_i.div_done) begin
          cmd.step_row_we = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_d    = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_en = 1'b1;
        state_d     = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    steps_ready_d = steps_ready_q;
    if (sts_i.cfg_hit) begin
      steps_ready_d = 1'b0;
    end else if (cmd.step_row_we) begin
      steps_ready_d = 1'b1;
    end else if (cmd.out_load && sts_i.last) begin
      steps_ready_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      steps_ready_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      steps_ready_q <= steps_ready_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ----- rtl/core/nnis_dp.sv -----
module nnis_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nnis_pkg::cmd_t                 cmd_i,
  output nnis_pkg::sts_t                 sts_o,
  input  logic                           cfg_we_i,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nnis_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    red_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    green_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    blue_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    alpha_in_i,
  output logic [nnis_pkg::CHAN_W-1:0]    red_out_o,
  output logic [nnis_pkg::CHAN_W-1:0]    green_out_o,
  output logic [nnis_pkg::CHAN_W-1:0]    blue_out_o,
  output logic [nnis_pkg::CHAN_W-1:0]    alpha_out_o,
  output logic                           last_pixel_o
);
  import nnis_pkg::*;

  logic [DIM_W-1:0]      src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic                  has_alpha_q;
  logic [DIM_W-1:0]      sw, sh, dw, dh;
  logic                  cfg_hit;

  logic [IDX_W-1:0]      load_idx_q;
  logic [COORD_W-1:0]    col_q, row_q;
  logic [STEP_W-1:0]     col_step_q, row_step_q;
  logic [PROD_W-1:0]     prod_x_q, prod_y_q;
  logic [COORD_W-1:0]    sx, sy;
  logic [SRC_ADDR_W-1:0] addr_q;
  logic                  rd_ok_q;
  logic [PIX_W-1:0]      rd_data_q;
  logic [PIX_W-1:0]      pix;
  logic [PIX_W-1:0]      mem [STORE_DEPTH];

  logic                  load_ok;
  logic                  col_end, row_end, last;
  logic [STEP_W-1:0]     dividend;
  logic [DIM_W-1:0]      divisor;
  logic                  div_done;
  logic [STEP_W-1:0]     quot;

  logic [CHAN_W-1:0]     red_q, green_q, blue_q, alpha_q;
  logic                  last_q;

  assign sw = clamp_dim(src_w_q);
  assign sh = clamp_dim(src_h_q);
  assign dw = clamp_dim(dst_w_q);
  assign dh = clamp_dim(dst_h_q);

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_W, CFG_SRC_H, CFG_DST_W, CFG_DST_H, CFG_ALPHA: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= DIM_W'(1);
      src_h_q     <= DIM_W'(1);
      dst_w_q     <= DIM_W'(1);
      dst_h_q     <= DIM_W'(1);
      has_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_W: src_w_q     <= cfg_data_i;
        CFG_SRC_H: src_h_q     <= cfg_data_i;
        CFG_DST_W: dst_w_q     <= cfg_data_i;
        CFG_DST_H: dst_h_q     <= cfg_data_i;
        CFG_ALPHA: has_alpha_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign dividend = cmd_i.div_row ? {sh, FRAC_BITS'(0)} : {sw, FRAC_BITS'(0)};
  assign divisor  = cmd_i.div_row ? dh : dw;

  nnis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign load_ok = load_idx_q < IDX_W'(STORE_DEPTH);
  assign col_end = ({1'b0, col_q} + DIM_W'(1)) >= dw;
  assign row_end = ({1'b0, row_q} + DIM_W'(1)) >= dh;
  assign last    = col_end && row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      col_step_q <= '0;
      row_step_q <= '0;
    end else begin
      if (cmd_i.load_we && load_ok) begin
        load_idx_q <= load_idx_q + IDX_W'(1);
      end
      if (cmd_i.emit_start) begin
        if ({1'b0, col_q} >= dw) begin
          col_q <= '0;
        end
        if ({1'b0, row_q} >= dh) begin
          row_q <= '0;
        end
      end
      if (cmd_i.step_col_we) begin
        col_step_q <= quot;
      end
      if (cmd_i.step_row_we) begin
        row_step_q <= quot;
      end
      if (cmd_i.out_load) begin
        if (last) begin
          col_q      <= '0;
          row_q      <= '0;
          load_idx_q <= '0;
        end else if (col_end) begin
          col_q <= '0;
          row_q <= row_q + COORD_W'(1);
        end else begin
          col_q <= col_q + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      mem[load_idx_q[ADDR_W-1:0]] <= {red_in_i, green_in_i, blue_in_i, alpha_in_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[addr_q[ADDR_W-1:0]];
    end
  end

  assign sx = prod_x_q[FRAC_BITS+COORD_W-1:FRAC_BITS];
  assign sy = prod_y_q[FRAC_BITS+COORD_W-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_x_q <= PROD_W'(col_q) * PROD_W'(col_step_q);
      prod_y_q <= PROD_W'(row_q) * PROD_W'(row_step_q);
    end
    if (cmd_i.addr_en) begin
      addr_q <= SRC_ADDR_W'(sy) * SRC_ADDR_W'(sw) + SRC_ADDR_W'(sx);
    end
    if (cmd_i.rd_en) begin
      rd_ok_q <= addr_q < SRC_ADDR_W'(STORE_DEPTH);
    end
  end

  assign pix = rd_ok_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      red_q   <= pix[PIX_W-1:PIX_W-CHAN_W];
      green_q <= pix[PIX_W-CHAN_W-1:PIX_W-2*CHAN_W];
      blue_q  <= pix[PIX_W-2*CHAN_W-1:PIX_W-3*CHAN_W];
      alpha_q <= has_alpha_q ? pix[CHAN_W-1:0] : '0;
      last_q  <= last;
    end
  end

  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign alpha_out_o  = alpha_q;
  assign last_pixel_o = last_q;

  assign sts_o.div_done = div_done;
  assign sts_o.last     = last;
  assign sts_o.cfg_hit  = cfg_hit;

endmodule

// ----- rtl/core/nearest_neighbor_image_scaler_top.sv -----
// Nearest-neighbor image scaler. A load beat (action 0) writes one RGBA source pixel into
// the pixel store at the next raster position, and the block stays ready; loads past the
// store depth are dropped. An emit beat (action 1) returns the next destination pixel in
// raster order and occupies the block for two registered multiplies, the store read and
// the output register load. The first emit after reset, after a register write or after
// the last pixel of an image also runs the two 11.16 step divisions on the shared
// bit-serial divider, one quotient bit per cycle. A finished pixel waits in the output
// register while the next beat is accepted. Registers must be written only while the block
// is idle; the block does not enforce it. Store entries never loaded read back as garbage.
module nearest_neighbor_image_scaler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nnis_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    red_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    green_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    blue_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    alpha_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [nnis_pkg::CHAN_W-1:0]    red_out_o,
  output logic [nnis_pkg::CHAN_W-1:0]    green_out_o,
  output logic [nnis_pkg::CHAN_W-1:0]    blue_out_o,
  output logic [nnis_pkg::CHAN_W-1:0]    alpha_out_o,
  output logic                           last_pixel_o
);
  import nnis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nnis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  nnis_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .alpha_in_i   (alpha_in_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

// ----- rtl/core/nnis_checker.sv -----
`include "nearest_neighbor_image_scaler_top_assert.svh"

module nnis_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           action_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [nnis_pkg::CHAN_W-1:0]    red_out_o,
  input logic                           last_pixel_o
);
  import nnis_pkg::*;

  `NNIS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(red_out_o) && $stable(last_pixel_o))
  `NNIS_ASSERT_NEXT(a_load_no_beat, clk_i, rst_ni, in_valid_i && in_ready_o && (action_i == ACT_LOAD) && !out_valid_o, !out_valid_o)
  `NNIS_ASSERT_NEXT(a_emit_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (action_i == ACT_EMIT), !in_ready_o)
  `NNIS_ASSERT_NOW(a_beat_after_emit, clk_i, rst_ni, $rose(out_valid_o), !in_ready_o || $past(in_ready_o, 1) == 1'b0)

endmodule

bind nearest_neighbor_image_scaler_top nnis_checker u_nnis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .action_i     (action_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .red_out_o    (red_out_o),
  .last_pixel_o (last_pixel_o)
);

// ----- bench/nnis_pixel_checker.sv -----
`timescale 1ns / 100ps

module nnis_pixel_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nnis_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           action_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    red_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    green_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    blue_in_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    alpha_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    red_out_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    green_out_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    blue_out_i,
  input  logic [nnis_pkg::CHAN_W-1:0]    alpha_out_i,
  input  logic                           last_pixel_i,
  output int                             errors_o,
  output int                             pending_o
);

  import nnis_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } dst_pixel_t;

  logic [PIX_W-1:0]   src_pixels [STORE_DEPTH];
  logic [IDX_W-1:0]   load_ptr;
  logic [COORD_W-1:0] dst_col;
  logic [COORD_W-1:0] dst_row;
  logic [STEP_W-1:0]  col_step_q;
  logic [STEP_W-1:0]  row_step_q;
  logic               steps_known;
  logic [DIM_W-1:0]   src_w_q;
  logic [DIM_W-1:0]   src_h_q;
  logic [DIM_W-1:0]   dst_w_q;
  logic [DIM_W-1:0]   dst_h_q;
  logic               alpha_on;
  dst_pixel_t         pixels_due [$];

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > DIM_W'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return int'(raw);
  endfunction

  task automatic scale_next_pixel();
    int unsigned      sw;
    int unsigned      sh;
    int unsigned      dw;
    int unsigned      dh;
    logic [63:0]      sx;
    logic [63:0]      sy;
    logic [63:0]      addr;
    logic [PIX_W-1:0] px;
    dst_pixel_t       pix;
    sw = eff_dim(src_w_q);
    sh = eff_dim(src_h_q);
    dw = eff_dim(dst_w_q);
    dh = eff_dim(dst_h_q);
    if (!steps_known) begin
      col_step_q  = STEP_W'((64'(sw) << FRAC_BITS) / 64'(dw));
      row_step_q  = STEP_W'((64'(sh) << FRAC_BITS) / 64'(dh));
      steps_known = 1'b1;
    end
    if (32'(dst_col) >= dw) begin
      dst_col = '0;
    end
    if (32'(dst_row) >= dh) begin
      dst_row = '0;
    end
    sx   = (64'(dst_col) * 64'(col_step_q)) >> FRAC_BITS;
    sy   = (64'(dst_row) * 64'(row_step_q)) >> FRAC_BITS;
    addr = sy * 64'(sw) + sx;
    px   = (addr < 64'(STORE_DEPTH)) ? src_pixels[addr[ADDR_W-1:0]] : '0;
    pix.red   = px[31:24];
    pix.green = px[23:16];
    pix.blue  = px[15:8];
    pix.alpha = alpha_on ? px[7:0] : '0;
    pix.last  = (32'(dst_col) + 1 >= dw) && (32'(dst_row) + 1 >= dh);
    pixels_due.push_back(pix);
    if (pix.last) begin
      dst_col     = '0;
      dst_row     = '0;
      load_ptr    = '0;
      steps_known = 1'b0;
    end else if (32'(dst_col) + 1 >= dw) begin
      dst_col = '0;
      dst_row = dst_row + 1'b1;
    end else begin
      dst_col = dst_col + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dst_pixel_t got;
    dst_pixel_t want;
    if (!rst_ni) begin
      load_ptr    = '0;
      dst_col     = '0;
      dst_row     = '0;
      col_step_q  = '0;
      row_step_q  = '0;
      steps_known = 1'b0;
      src_w_q     = DIM_W'(1);
      src_h_q     = DIM_W'(1);
      dst_w_q     = DIM_W'(1);
      dst_h_q     = DIM_W'(1);
      alpha_on    = 1'b0;
      pixels_due.delete();
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SRC_W: begin
            src_w_q     = cfg_data_i;
            steps_known = 1'b0;
          end
          CFG_SRC_H: begin
            src_h_q     = cfg_data_i;
            steps_known = 1'b0;
          end
          CFG_DST_W: begin
            dst_w_q     = cfg_data_i;
            steps_known = 1'b0;
          end
          CFG_DST_H: begin
            dst_h_q     = cfg_data_i;
            steps_known = 1'b0;
          end
          CFG_ALPHA: begin
            alpha_on    = cfg_data_i[0];
            steps_known = 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_LOAD) begin
          if (load_ptr < IDX_W'(STORE_DEPTH)) begin
            src_pixels[load_ptr[ADDR_W-1:0]] = {red_in_i, green_in_i, blue_in_i, alpha_in_i};
            load_ptr = load_ptr + 1'b1;
          end
        end else begin
          scale_next_pixel();
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = {red_out_i, green_out_i, blue_out_i, alpha_out_i, last_pixel_i};
        if (pixels_due.size() == 0) begin
          if (errors_o < 10) begin
            $display("%0t: output beat with nothing expected: r=%h g=%h b=%h a=%h last=%b",
                     $time, got.red, got.green, got.blue, got.alpha, got.last);
          end
          errors_o++;
        end else begin
          want = pixels_due.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.alpha !== want.alpha || got.last !== want.last) begin
            if (errors_o < 10) begin
              $display("%0t: pixel mismatch: expected r=%h g=%h b=%h a=%h last=%b",
                       $time, want.red, want.green, want.blue, want.alpha, want.last);
              $display("%0t:                  got      r=%h g=%h b=%h a=%h last=%b",
                       $time, got.red, got.green, got.blue, got.alpha, got.last);
            end
            errors_o++;
          end
        end
      end
      pending_o = pixels_due.size();
    end
  end

endmodule

// ----- bench/tb_nearest_neighbor_image_scaler_top.sv -----
`timescale 1ns / 100ps

module tb_nearest_neighbor_image_scaler_top;

  import nnis_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_BEATS  = 1600;
  localparam int EMIT_CAP      = 150;
  localparam int LOAD_CAP      = 120;
  localparam int FILL_BEATS    = 128;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [DIM_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 action     = ACT_LOAD;
  logic [CHAN_W-1:0]    red_in     = '0;
  logic [CHAN_W-1:0]    green_in   = '0;
  logic [CHAN_W-1:0]    blue_in    = '0;
  logic [CHAN_W-1:0]    alpha_in   = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b1;
  logic [CHAN_W-1:0]    red_out;
  logic [CHAN_W-1:0]    green_out;
  logic [CHAN_W-1:0]    blue_out;
  logic [CHAN_W-1:0]    alpha_out;
  logic                 last_pixel;

  int          fail_cnt;
  int          due_cnt;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          beats_sent    = 0;
  int unsigned cur_sw        = 1;
  int unsigned cur_sh        = 1;
  int unsigned cur_dw        = 1;
  int unsigned cur_dh        = 1;

  nearest_neighbor_image_scaler_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .alpha_in_i   (alpha_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .red_out_o    (red_out),
    .green_out_o  (green_out),
    .blue_out_o   (blue_out),
    .alpha_out_o  (alpha_out),
    .last_pixel_o (last_pixel)
  );

  nnis_pixel_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .alpha_in_i   (alpha_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .red_out_i    (red_out),
    .green_out_i  (green_out),
    .blue_out_i   (blue_out),
    .alpha_out_i  (alpha_out),
    .last_pixel_i (last_pixel),
    .errors_o     (fail_cnt),
    .pending_o    (due_cnt)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_beat(input logic act, input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    alpha_in <= a;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic load_pixel();
    send_beat(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic emit_pixel();
    send_beat(ACT_EMIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_cnt != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dim(input cfg_idx_e idx, input int unsigned eff, input logic [DIM_W-1:0] raw);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= raw;
    case (idx)
      CFG_SRC_W: cur_sw = eff;
      CFG_SRC_H: cur_sh = eff;
      CFG_DST_W: cur_dw = eff;
      CFG_DST_H: cur_dh = eff;
      default: begin
      end
    endcase
  endtask

  task automatic write_alpha(input logic on);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ALPHA;
    cfg_data <= DIM_W'(on);
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return $urandom_range(1, 6);
    end else if (r < 85) begin
      return $urandom_range(7, 24);
    end else if (r < 94) begin
      return $urandom_range(25, MAX_DIM - 1);
    end
    return MAX_DIM;
  endfunction

  function automatic int unsigned pick_src_width();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(17, FILL_BEATS);
    end
    return $urandom_range(1, 16);
  endfunction

  function automatic logic [DIM_W-1:0] raw_dim(input int unsigned eff);
    if (eff == 1 && $urandom_range(1) == 0) begin
      return '0;
    end
    if (eff == MAX_DIM) begin
      return DIM_W'($urandom_range(MAX_DIM, 2 ** DIM_W - 1));
    end
    return DIM_W'(eff);
  endfunction

  task automatic run_frame(input bit hold);
    int unsigned e;
    int unsigned sw_next;
    int unsigned cap;
    int unsigned n_load;
    int unsigned n_emit;
    int unsigned total;
    wait_idle();
    sw_next = cur_sw;
    if ($urandom_range(9) < 7) begin
      sw_next = pick_src_width();
      write_dim(CFG_SRC_W, sw_next, raw_dim(sw_next));
    end
    if ($urandom_range(9) < 7 || sw_next * cur_sh > FILL_BEATS) begin
      e = $urandom_range(1, FILL_BEATS / sw_next);
      write_dim(CFG_SRC_H, e, raw_dim(e));
    end
    if ($urandom_range(9) < 7) begin
      e = pick_dim();
      write_dim(CFG_DST_W, e, raw_dim(e));
    end
    if ($urandom_range(9) < 7) begin
      e = pick_dim();
      write_dim(CFG_DST_H, e, raw_dim(e));
    end
    if ($urandom_range(9) < 3) begin
      write_alpha(1'($urandom_range(1)));
    end
    close_writes();
    cap    = (cur_sw * cur_sh > LOAD_CAP) ? LOAD_CAP : cur_sw * cur_sh;
    n_load = ($urandom_range(4) != 0) ? cap : $urandom_range(0, cap);
    repeat (n_load) load_pixel();
    total = cur_dw * cur_dh;
    if (total > EMIT_CAP) begin
      n_emit = $urandom_range(1, EMIT_CAP);
    end else if ($urandom_range(6) == 0) begin
      n_emit = $urandom_range(1, total);
    end else begin
      n_emit = total;
    end
    for (int i = 0; i < n_emit; i++) begin
      if (hold && i == n_emit / 2) begin
        wait_results();
      end
      if ($urandom_range(9) == 0) begin
        load_pixel();
      end
      emit_pixel();
    end
  endtask

  initial begin
    int target;
    bit first;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Fill the first entries of the store. Later images read only these entries
    // or addresses past the end of the store.
    repeat (FILL_BEATS) load_pixel();
    emit_pixel();

    wait_idle();
    write_dim(CFG_SRC_W, 2, DIM_W'(2));
    write_dim(CFG_SRC_H, 2, DIM_W'(2));
    write_dim(CFG_DST_W, 3, DIM_W'(3));
    write_dim(CFG_DST_H, 2, DIM_W'(2));
    write_alpha(1'b1);
    close_writes();
    send_beat(ACT_LOAD, 8'h00, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    load_pixel();
    send_beat(ACT_LOAD, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
    repeat (6) emit_pixel();

    // The second row maps far beyond the end of the store.
    wait_idle();
    write_dim(CFG_SRC_W, MAX_DIM, {DIM_W{1'b1}});
    write_dim(CFG_SRC_H, MAX_DIM, DIM_W'(MAX_DIM));
    write_dim(CFG_DST_W, 1, DIM_W'(1));
    write_dim(CFG_DST_H, 2, DIM_W'(2));
    close_writes();
    repeat (2) emit_pixel();

    wait_idle();
    write_dim(CFG_SRC_W, 1, '0);
    write_dim(CFG_SRC_H, 1, '0);
    write_dim(CFG_DST_W, 1, '0);
    write_dim(CFG_DST_H, 1, '0);
    write_alpha(1'b0);
    close_writes();
    emit_pixel();

    // Stop inside the image, then shrink it so the position lies outside.
    wait_idle();
    write_dim(CFG_SRC_W, 4, DIM_W'(4));
    write_dim(CFG_SRC_H, 4, DIM_W'(4));
    write_dim(CFG_DST_W, 4, DIM_W'(4));
    write_dim(CFG_DST_H, 4, DIM_W'(4));
    close_writes();
    repeat (6) emit_pixel();
    wait_idle();
    write_dim(CFG_DST_W, 2, DIM_W'(2));
    write_dim(CFG_DST_H, 1, DIM_W'(1));
    close_writes();
    repeat (2) emit_pixel();

    wait_idle();
    write_dim(CFG_SRC_W, 1, DIM_W'(1));
    write_dim(CFG_SRC_H, 1, DIM_W'(1));
    write_dim(CFG_DST_W, MAX_DIM, DIM_W'(MAX_DIM));
    write_dim(CFG_DST_H, MAX_DIM, DIM_W'(MAX_DIM + 1));
    close_writes();
    repeat (3) emit_pixel();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 62;
        end
        default: begin
          send_idle_pct = 20;
          stall_pct     = 20;
        end
      endcase
      first  = 1'b1;
      target = beats_sent + RANDOM_BEATS / 4;
      while (beats_sent < target) begin
        run_frame(first || $urandom_range(9) == 0);
        first = 1'b0;
      end
    end

    wait_idle();
    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
